// ----- rtl/periodic_timer_queue_defines.svh -----
// ----------------------------------------------------------------------------
// periodic_timer_queue_defines
// assertion macros used by the timer queue top level
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_QUEUE_DEFINES_SVH
`define PERIODIC_TIMER_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PTQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptq assertion failed");
`define PTQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptq assertion failed");
`else
`define PTQ_ASSERT_IMP(lbl, ante, cons)
`define PTQ_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/ptq_pkg.sv -----
// ----------------------------------------------------------------------------
// ptq_pkg
// types and constants of the periodic timer queue
// ----------------------------------------------------------------------------
package ptq_pkg;

  localparam int NUM_TIMERS       = 16;
  localparam int MAX_TICK_RESULTS = 64;
  localparam int ID_W             = $clog2(NUM_TIMERS);
  localparam int CNT_W            = $clog2(MAX_TICK_RESULTS + 1);
  localparam int SCAN_W           = $clog2(NUM_TIMERS + 1);
  localparam int NS_PER_US        = 1000;
  localparam int JITTER_STEPS     = 100;
  localparam logic [15:0] LFSR_MASK = 16'hB400;
  localparam int DIV_W            = 29;
  localparam int RECIP_W          = 26;
  localparam int DIV25_MUL        = 42949673;
  localparam int DIV25_SHIFT      = 30;
  localparam int QUOT_W           = DIV_W + RECIP_W - DIV25_SHIFT;
  localparam int PROD_W           = 43;

  typedef enum logic [1:0] {
    OP_ARM    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2
  } opcode_e;

  typedef enum logic {
    EV_FIRED    = 1'b0,
    EV_DETACHED = 1'b1
  } event_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ARM,
    WR_CANCEL,
    WR_DEADLINE,
    WR_RETIRE
  } wr_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ARM_MUL,
    S_ARM_WR,
    S_CANCEL,
    S_SCAN,
    S_DECIDE,
    S_PUSH_FIRED,
    S_PUSH_DET,
    S_RETIRE,
    S_LFSR,
    S_MOD,
    S_MUL_J,
    S_DIV_Q,
    S_JIT_DIV,
    S_JIT_SUM,
    S_MUL_NS,
    S_UPD,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  timer_id;
    logic [30:0] period_us;
    logic        one_shot;
    logic [29:0] jitter_us;
    logic [62:0] now_ns;
  } in_item_t;

  typedef struct packed {
    logic [3:0] slot;
    logic       event_kind;
    logic       last;
  } out_item_t;

  typedef struct packed {
    wr_op_e            op;
    logic [ID_W-1:0]   id;
    logic [63:0]       deadline;
    logic [30:0]       period;
    logic [29:0]       jitter;
    logic              single;
  } wr_t;

  typedef struct packed {
    logic              found;
    logic [ID_W-1:0]   id;
    logic [63:0]       deadline;
    logic [30:0]       period;
    logic [29:0]       jitter;
    logic              enabled;
    logic              single;
  } cand_t;

  typedef struct packed {
    logic             pend_v;
    logic [CNT_W-1:0] cnt;
  } stat_t;

endpackage

// ----- rtl/ptq_if.sv -----
// ----------------------------------------------------------------------------
// ptq_if
// valid/ready channels of the timer queue
// ----------------------------------------------------------------------------
interface ptq_in_if import ptq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ptq_out_if import ptq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/ptq_cell.sv -----
// ----------------------------------------------------------------------------
// ptq_cell
// one timer slot; passes the earliest queued candidate to its neighbor
// ----------------------------------------------------------------------------
module ptq_cell import ptq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [ID_W-1:0] cell_id_i,
  input  wr_t             wr_i,
  input  cand_t           cand_i,
  output cand_t           cand_o
);

  logic [63:0] deadline_q, deadline_d;
  logic [30:0] period_q, period_d;
  logic [29:0] jitter_q, jitter_d;
  logic        queued_q, queued_d;
  logic        enabled_q, enabled_d;
  logic        single_q, single_d;
  logic        hit;
  cand_t       cand_d, cand_q;

  assign hit = (wr_i.id == cell_id_i);

  always_comb begin
    deadline_d = deadline_q;
    period_d   = period_q;
    jitter_d   = jitter_q;
    queued_d   = queued_q;
    enabled_d  = enabled_q;
    single_d   = single_q;
    if (hit) begin
      case (wr_i.op)
        WR_ARM: begin
          deadline_d = wr_i.deadline;
          period_d   = wr_i.period;
          jitter_d   = wr_i.jitter;
          single_d   = wr_i.single;
          queued_d   = 1'b1;
          enabled_d  = 1'b1;
        end
        WR_CANCEL:   enabled_d = 1'b0;
        WR_DEADLINE: deadline_d = wr_i.deadline;
        WR_RETIRE: begin
          queued_d  = 1'b0;
          enabled_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cand_d = cand_i;
    if (queued_q && (!cand_i.found || deadline_q < cand_i.deadline)) begin
      cand_d.found    = 1'b1;
      cand_d.id       = cell_id_i;
      cand_d.deadline = deadline_q;
      cand_d.period   = period_q;
      cand_d.jitter   = jitter_q;
      cand_d.enabled  = enabled_q;
      cand_d.single   = single_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= '0;
      period_q   <= '0;
      jitter_q   <= '0;
      queued_q   <= 1'b0;
      enabled_q  <= 1'b0;
      single_q   <= 1'b0;
      cand_q     <= '0;
    end else begin
      deadline_q <= deadline_d;
      period_q   <= period_d;
      jitter_q   <= jitter_d;
      queued_q   <= queued_d;
      enabled_q  <= enabled_d;
      single_q   <= single_d;
      cand_q     <= cand_d;
    end
  end

  assign cand_o = cand_q;

endmodule

// ----- rtl/ptq_div.sv -----
// ----------------------------------------------------------------------------
// ptq_div
// quotient by 25 through a reciprocal multiply, ready in the cycle after start
// ----------------------------------------------------------------------------
module ptq_div import ptq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  logic                      done_q;
  logic [QUOT_W-1:0]         quot_q;
  logic [DIV_W+RECIP_W-1:0]  prod;

  assign prod = {{RECIP_W{1'b0}}, dividend_i} * (DIV_W+RECIP_W)'(DIV25_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= prod[DIV25_SHIFT +: QUOT_W];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/ptq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptq_ctrl
// sequencer: commands, per-pop decisions, jitter, result buffering
// ----------------------------------------------------------------------------
module ptq_ctrl import ptq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ptq_in_if.sink            in_i,
  ptq_out_if.source         out_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  cand_t             best_i,
  output wr_t               wr_o,
  output logic              div_start_o,
  output logic [DIV_W-1:0]  div_dividend_o,
  input  logic              div_done_i,
  input  logic [QUOT_W-1:0] div_quot_i,
  output stat_t             stat_o
);

  state_e            state_q, state_d;
  logic [62:0]       now_q, now_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [30:0]       per_q, per_d;
  logic [29:0]       jit_q, jit_d;
  logic              single_q, single_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SCAN_W-1:0] scan_q, scan_d;
  logic              pend_v_q, pend_v_d;
  logic [ID_W-1:0]   pend_id_q, pend_id_d;
  logic              pend_kind_q, pend_kind_d;
  logic              out_v_q, out_v_d;
  out_item_t         out_q, out_d;
  logic [15:0]       lfsr_q, lfsr_d;
  logic [15:0]       lfsr_step;
  logic [32:0]       iv_q, iv_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [QUOT_W-1:0] qa_q, qa_d;
  logic [6:0]        rnd_q, rnd_d;
  logic [5:0]        jb_q, jb_d;
  logic [12:0]       rb_q, rb_d;
  logic [31:0]       ra_q, ra_d;
  logic              out_free;
  logic              can_push;
  logic [CNT_W:0]    need_sum;
  logic [32:0]       up;
  logic [15:0]       rem16;
  logic [29:0]       jb_full;

  assign lfsr_step = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_MASK) : (lfsr_q >> 1);
  assign out_free  = !out_v_q || out_o.ready;
  assign can_push  = !pend_v_q || out_free;
  assign need_sum  = {1'b0, cnt_q} +
                     ((best_i.enabled && best_i.single) ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
  assign rem16     = lfsr_q - ({6'd0, div_quot_i[9:0]} * 16'(JITTER_STEPS));
  assign jb_full   = best_i.jitter - ({5'd0, qa_q} * 30'(JITTER_STEPS / 2));
  assign up        = {2'b0, best_i.period} + {1'b0, ra_q} + {8'b0, div_quot_i};

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    id_d        = id_q;
    per_d       = per_q;
    jit_d       = jit_q;
    single_d    = single_q;
    cnt_d       = cnt_q;
    scan_d      = scan_q;
    pend_v_d    = pend_v_q;
    pend_id_d   = pend_id_q;
    pend_kind_d = pend_kind_q;
    out_v_d     = out_v_q && !out_o.ready;
    out_d       = out_q;
    lfsr_d      = lfsr_q;
    iv_d        = iv_q;
    prod_d      = prod_q;
    qa_d        = qa_q;
    rnd_d       = rnd_q;
    jb_d        = jb_q;
    rb_d        = rb_q;
    ra_d        = ra_q;
    wr_o        = '0;
    wr_o.op     = WR_NONE;
    wr_o.id     = best_i.id;
    div_start_o    = 1'b0;
    div_dividend_o = '0;
    in_i.ready     = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          now_d    = in_i.payload.now_ns;
          id_d     = ID_W'(in_i.payload.timer_id);
          per_d    = in_i.payload.period_us;
          jit_d    = in_i.payload.jitter_us;
          single_d = in_i.payload.one_shot;
          iv_d     = {2'b0, in_i.payload.period_us};
          case (in_i.payload.opcode)
            OP_ARM:    state_d = (int'(in_i.payload.timer_id) < NUM_TIMERS) ?
                                 S_ARM_MUL : S_FINISH;
            OP_CANCEL: state_d = (int'(in_i.payload.timer_id) < NUM_TIMERS) ?
                                 S_CANCEL : S_FINISH;
            OP_TICK: begin
              cnt_d   = '0;
              scan_d  = '0;
              state_d = S_SCAN;
            end
            default:   state_d = S_FINISH;
          endcase
        end
      end
      S_ARM_MUL: begin
        prod_d  = {10'd0, iv_q} * PROD_W'(NS_PER_US);
        state_d = S_ARM_WR;
      end
      S_ARM_WR: begin
        wr_o.op       = WR_ARM;
        wr_o.id       = id_q;
        wr_o.deadline = {1'b0, now_q} + 64'(prod_q);
        wr_o.period   = per_q;
        wr_o.jitter   = jit_q;
        wr_o.single   = single_q;
        state_d       = S_IDLE;
      end
      S_CANCEL: begin
        wr_o.op = WR_CANCEL;
        wr_o.id = id_q;
        state_d = S_IDLE;
      end
      S_SCAN: begin
        scan_d = scan_q + 1'b1;
        if (scan_q == SCAN_W'(NUM_TIMERS - 1)) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!best_i.found || best_i.deadline > {1'b0, now_q}) begin
          state_d = S_FINISH;
        end else if (need_sum > (CNT_W+1)'(MAX_TICK_RESULTS)) begin
          state_d = S_FINISH;
        end else if (best_i.enabled) begin
          state_d = S_PUSH_FIRED;
        end else begin
          state_d = S_PUSH_DET;
        end
      end
      S_PUSH_FIRED, S_PUSH_DET: begin
        if (can_push) begin
          if (pend_v_q) begin
            out_v_d     = 1'b1;
            out_d.slot  = 4'(pend_id_q);
            out_d.event_kind = pend_kind_q;
            out_d.last  = 1'b0;
          end
          pend_v_d  = 1'b1;
          pend_id_d = best_i.id;
          cnt_d     = cnt_q + 1'b1;
          if (state_q == S_PUSH_DET) begin
            pend_kind_d = EV_DETACHED;
            state_d     = S_RETIRE;
          end else begin
            pend_kind_d = EV_FIRED;
            iv_d        = {2'b0, best_i.period};
            if (best_i.single) begin
              state_d = S_PUSH_DET;
            end else if (best_i.jitter != '0) begin
              state_d = S_LFSR;
            end else begin
              state_d = S_MUL_NS;
            end
          end
        end
      end
      S_RETIRE: begin
        wr_o.op = WR_RETIRE;
        scan_d  = '0;
        state_d = S_SCAN;
      end
      S_LFSR: begin
        lfsr_d         = lfsr_step;
        div_start_o    = 1'b1;
        div_dividend_o = best_i.jitter[29:1];
        state_d        = S_MOD;
      end
      S_MOD: begin
        if (div_done_i) begin
          qa_d           = div_quot_i;
          div_start_o    = 1'b1;
          div_dividend_o = {15'd0, lfsr_q[15:2]};
          state_d        = S_MUL_J;
        end
      end
      S_MUL_J: begin
        if (div_done_i) begin
          rnd_d   = rem16[6:0] + 7'd1;
          jb_d    = jb_full[5:0];
          state_d = S_DIV_Q;
        end
      end
      S_DIV_Q: begin
        rb_d    = {6'd0, rnd_q} * {7'd0, jb_q};
        ra_d    = {25'd0, rnd_q} * {7'd0, qa_q};
        state_d = S_JIT_DIV;
      end
      S_JIT_DIV: begin
        div_start_o    = 1'b1;
        div_dividend_o = {17'd0, rb_q[12:1]};
        state_d        = S_JIT_SUM;
      end
      S_JIT_SUM: begin
        if (div_done_i) begin
          iv_d    = (up > {3'b0, best_i.jitter}) ? (up - {3'b0, best_i.jitter}) : '0;
          state_d = S_MUL_NS;
        end
      end
      S_MUL_NS: begin
        prod_d  = {10'd0, iv_q} * PROD_W'(NS_PER_US);
        state_d = S_UPD;
      end
      S_UPD: begin
        wr_o.op       = WR_DEADLINE;
        wr_o.deadline = best_i.deadline + 64'(prod_q);
        scan_d        = '0;
        state_d       = S_SCAN;
      end
      S_FINISH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_v_d          = 1'b1;
          out_d.slot       = 4'(pend_id_q);
          out_d.event_kind = pend_kind_q;
          out_d.last       = 1'b1;
          pend_v_d         = 1'b0;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      lfsr_d = (cfg_wdata_i == '0) ? 16'd1 : cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      scan_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      lfsr_q   <= 16'd1;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      scan_q   <= scan_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      lfsr_q   <= lfsr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    id_q        <= id_d;
    per_q       <= per_d;
    jit_q       <= jit_d;
    single_q    <= single_d;
    pend_id_q   <= pend_id_d;
    pend_kind_q <= pend_kind_d;
    out_q       <= out_d;
    iv_q        <= iv_d;
    prod_q      <= prod_d;
    qa_q        <= qa_d;
    rnd_q       <= rnd_d;
    jb_q        <= jb_d;
    rb_q        <= rb_d;
    ra_q        <= ra_d;
  end

  assign out_o.valid   = out_v_q;
  assign out_o.payload = out_q;
  assign stat_o.pend_v = pend_v_q;
  assign stat_o.cnt    = cnt_q;

endmodule

// ----- rtl/periodic_timer_queue.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_queue
// timer slots served in earliest-deadline order through a chain of cells
// ----------------------------------------------------------------------------
// channel   dir  payload                                          transaction
// in_i      in   opcode timer_id period_us one_shot jitter now    valid & ready
// out_o     out  slot event_kind last                              valid & ready
// cfg       in   random_seed (16 bit)                             cfg_we_i
//
// arm (multiply, write) and cancel (write) hold off the input until the command ends
// a tick scans the whole cell chain, then decides on the earliest slot; a detached slot
// is pushed and retired, a fired one-shot also pushed as detached, a periodic one rearmed
// a periodic slot with jitter draws its random step by reciprocal division by 25
// the chain is scanned anew after each slot; the tick closes with a scan, a decide and a finish
// reset clears all slots and loads the generator with 1
// a stalled output holds the sequencer only when a second result is waiting
// ----------------------------------------------------------------------------
`include "periodic_timer_queue_defines.svh"

module periodic_timer_queue import ptq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptq_in_if.sink      in_i,
  ptq_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  cand_t             cand [NUM_TIMERS+1];
  wr_t               wr;
  stat_t             stat;
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;

  assign cand[0] = '0;

  for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
    ptq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (ID_W'(k)),
      .wr_i      (wr),
      .cand_i    (cand[k]),
      .cand_o    (cand[k+1])
    );
  end

  ptq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  ptq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .out_o          (out_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .best_i         (cand[NUM_TIMERS]),
    .wr_o           (wr),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_done_i     (div_done),
    .div_quot_i     (div_quot),
    .stat_o         (stat)
  );

  `PTQ_ASSERT_IMP(a_pend_only_busy, stat.pend_v, !in_i.ready)
  `PTQ_ASSERT_NXT(a_cmd_leaves_idle, in_i.valid && in_i.ready, !in_i.ready)
  `PTQ_ASSERT_IMP(a_cnt_cap, stat.pend_v, stat.cnt <= CNT_W'(MAX_TICK_RESULTS))

endmodule

// ----- tb/tb_periodic_timer_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_timer_queue
// self-checking testbench of the earliest-deadline timer queue
// ----------------------------------------------------------------------------
// arm, cancel and tick commands go in through a queue-fed driver; a shadow
// model of the slots predicts the fired and detached events of every tick,
// and a monitor compares each output transaction in order. random idling on
// both sides, a long output hold-off and several jitter seeds are exercised.
// ----------------------------------------------------------------------------
module tb_periodic_timer_queue;
  import ptq_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int WDOG_LIMIT  = 40000;
  localparam int DRAIN_WAIT  = 300;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;

  ptq_in_if  in_if ();
  ptq_out_if out_if ();

  periodic_timer_queue DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // shadow slot state
  logic [63:0] sh_deadline [NUM_TIMERS];
  logic [30:0] sh_period   [NUM_TIMERS];
  logic [29:0] sh_jitter   [NUM_TIMERS];
  logic        sh_queued   [NUM_TIMERS];
  logic        sh_enabled  [NUM_TIMERS];
  logic        sh_single   [NUM_TIMERS];
  logic [15:0] sh_lfsr;

  in_item_t  cmd_q [$];
  out_item_t events_q [$];

  int  n_errors;
  int  n_cmds;
  int  n_events;
  int  n_ticks;
  int  wdog;
  bit  no_idle;
  bit  hold_req;
  bit  in_acc;
  int  hold_left;
  logic [62:0] t_now;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what, input out_item_t got, input out_item_t exp_ev);
    n_errors++;
    $display("mismatch %s: got slot %0d kind %0d last %0d, exp slot %0d kind %0d last %0d",
             what, got.slot, got.event_kind, got.last, exp_ev.slot, exp_ev.event_kind,
             exp_ev.last);
  endtask

  function automatic logic [63:0] jittered_period(input int s);
    logic [63:0] j;
    logic [63:0] iv;
    logic [63:0] r;
    logic [63:0] up;
    logic        lsb;
    j  = {34'd0, sh_jitter[s]};
    iv = {33'd0, sh_period[s]};
    if (j != 0) begin
      lsb = sh_lfsr[0];
      sh_lfsr = sh_lfsr >> 1;
      if (lsb) sh_lfsr = sh_lfsr ^ LFSR_MASK;
      r  = {48'd0, sh_lfsr} % JITTER_STEPS + 1;
      up = iv + (r * (j * 2)) / JITTER_STEPS;
      iv = (up > j) ? up - j : 64'd0;
    end
    return iv;
  endfunction

  function automatic void push_event(input int s, input event_e k);
    out_item_t e;
    e.slot       = s[3:0];
    e.event_kind = k;
    e.last       = 1'b0;
    events_q.push_back(e);
  endfunction

  function automatic void predict_command(input in_item_t c);
    int  best;
    int  n;
    int  need;
    bit  found;
    out_item_t e;
    case (c.opcode)
      OP_ARM: begin
        sh_period[c.timer_id]   = c.period_us;
        sh_single[c.timer_id]   = c.one_shot;
        sh_jitter[c.timer_id]   = c.jitter_us;
        sh_deadline[c.timer_id] = {1'b0, c.now_ns} + {33'd0, c.period_us} * NS_PER_US;
        sh_queued[c.timer_id]   = 1'b1;
        sh_enabled[c.timer_id]  = 1'b1;
      end
      OP_CANCEL: sh_enabled[c.timer_id] = 1'b0;
      OP_TICK: begin
        n = 0;
        forever begin
          found = 0;
          best  = 0;
          for (int s = 0; s < NUM_TIMERS; s++) begin
            if (sh_queued[s] && (!found || sh_deadline[s] < sh_deadline[best])) begin
              best  = s;
              found = 1;
            end
          end
          if (!found || sh_deadline[best] > {1'b0, c.now_ns}) break;
          need = (sh_enabled[best] && sh_single[best]) ? 2 : 1;
          if (n + need > MAX_TICK_RESULTS) break;
          if (sh_enabled[best]) begin
            push_event(best, EV_FIRED);
            n++;
            if (sh_single[best]) begin
              sh_enabled[best] = 1'b0;
              sh_queued[best]  = 1'b0;
              push_event(best, EV_DETACHED);
              n++;
            end else begin
              sh_deadline[best] = sh_deadline[best] + jittered_period(best) * NS_PER_US;
            end
          end else begin
            sh_queued[best] = 1'b0;
            push_event(best, EV_DETACHED);
            n++;
          end
        end
        if (n > 0) begin
          e = events_q.pop_back();
          e.last = 1'b1;
          events_q.push_back(e);
        end
      end
      default: ;
    endcase
  endfunction

  // driver
  initial begin
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    out_if.ready  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_acc)) begin
      in_acc = 1'b0;
      if (cmd_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 34)) begin
        in_if.payload <= cmd_q.pop_front();
        in_if.valid   <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // output sink with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rst_ni && (no_idle || $urandom_range(0, 99) >= 34);
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        in_acc = 1'b1;
        predict_command(in_if.payload);
        n_cmds++;
        if (in_if.payload.opcode == OP_TICK) n_ticks++;
      end
      if (out_if.valid && out_if.ready) begin
        n_events++;
        if (events_q.size() == 0) begin
          report("unexpected transaction", out_if.payload, '0);
        end else if (out_if.payload != events_q[0]) begin
          report("field", out_if.payload, events_q.pop_front());
        end else begin
          void'(events_q.pop_front());
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
          || (cmd_q.size() == 0 && events_q.size() == 0 && !in_if.valid)) begin
        wdog = 0;
      end else begin
        wdog++;
        if (wdog >= WDOG_LIMIT) begin
          $display("watchdog expired with %0d events outstanding", events_q.size());
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  task automatic add_cmd(input opcode_e op, input logic [3:0] id, input logic [30:0] iv,
                         input logic os, input logic [29:0] jit, input logic [62:0] now);
    in_item_t c;
    c.opcode    = op;
    c.timer_id  = id;
    c.period_us = iv;
    c.one_shot  = os;
    c.jitter_us = jit;
    c.now_ns    = now;
    cmd_q.push_back(c);
  endtask

  task automatic wait_drained(input int extra);
    while (cmd_q.size() > 0 || events_q.size() > 0 || in_if.valid) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_seed(input logic [15:0] seed);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = seed;
    sh_lfsr     = (seed == 0) ? 16'd1 : seed;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_cmds(input int count);
    logic [30:0] iv;
    logic [29:0] jit;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        iv  = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(1, 40));
        jit = ($urandom_range(0, 2) == 0) ? 30'd0 :
              ($urandom_range(0, 9) == 0) ? 30'($urandom) : 30'($urandom_range(1, 20));
        add_cmd(OP_ARM, 4'($urandom), iv, 1'($urandom), jit, t_now);
      end else if (pick < 52) begin
        add_cmd(OP_CANCEL, 4'($urandom), 31'($urandom), 1'($urandom), 30'($urandom), t_now);
      end else if (pick < 96) begin
        t_now = t_now + $urandom_range(0, 30000);
        add_cmd(OP_TICK, 4'($urandom), 31'($urandom), 1'($urandom), 30'($urandom), t_now);
      end else if (pick < 98) begin
        add_cmd(opcode_e'(2'd3), 4'($urandom), 31'($urandom), 1'($urandom),
                30'($urandom), {$urandom, $urandom});
      end else begin
        add_cmd(opcode_e'(2'($urandom_range(0, 2))), 4'($urandom), 31'($urandom),
                1'($urandom), 30'($urandom), {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    n_errors  = 0;
    n_cmds    = 0;
    n_events  = 0;
    n_ticks   = 0;
    wdog      = 0;
    no_idle   = 0;
    hold_req  = 0;
    in_acc    = 0;
    hold_left = 0;
    t_now     = 63'd1000;
    for (int s = 0; s < NUM_TIMERS; s++) begin
      sh_deadline[s] = '0;
      sh_period[s]   = '0;
      sh_jitter[s]   = '0;
      sh_queued[s]   = 1'b0;
      sh_enabled[s]  = 1'b0;
      sh_single[s]   = 1'b0;
    end
    sh_lfsr = 16'd1;
    rst_ni  = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (40) @(negedge clk_i);

    // directed: reset seed, result cap, cancel, extremes, unused opcode
    add_cmd(OP_TICK, 4'd0, 31'd0, 1'b0, 30'd0, 63'd0);
    add_cmd(OP_ARM, 4'd0, 31'd0, 1'b0, 30'd0, 63'd500);
    add_cmd(OP_TICK, 4'd0, 31'd0, 1'b0, 30'd0, 63'd499);
    add_cmd(OP_TICK, 4'd0, 31'd0, 1'b0, 30'd0, 63'd500);
    add_cmd(OP_CANCEL, 4'd0, 31'd0, 1'b0, 30'd0, 63'd0);
    add_cmd(OP_TICK, 4'd0, 31'd0, 1'b0, 30'd0, 63'd600);
    add_cmd(OP_ARM, 4'd3, 31'd2, 1'b1, 30'd0, 63'd1000);
    add_cmd(OP_ARM, 4'd4, 31'd2, 1'b1, 30'd0, 63'd1000);
    add_cmd(OP_ARM, 4'd5, 31'd1, 1'b0, 30'h3FFFFFFF, 63'd1000);
    add_cmd(OP_ARM, 4'd6, 31'd5, 1'b0, 30'd3, 63'd1000);
    add_cmd(OP_TICK, 4'd0, 31'd0, 1'b0, 30'd0, 63'd40000);
    add_cmd(OP_ARM, 4'd15, 31'h7FFFFFFF, 1'b1, 30'h3FFFFFFF, 63'd0);
    add_cmd(OP_ARM, 4'd14, 31'h7FFFFFFF, 1'b0, 30'd0, 63'h7FFFFFFFFFFFFFFF);
    add_cmd(opcode_e'(2'd3), 4'd15, 31'h7FFFFFFF, 1'b1, 30'h3FFFFFFF, 63'h7FFFFFFFFFFFFFFF);
    add_cmd(OP_TICK, 4'd0, 31'd0, 1'b0, 30'd0, 63'h7FFFFFFFFFFFFFFF);
    add_cmd(OP_CANCEL, 4'd14, 31'd0, 1'b0, 30'd0, 63'd0);
    add_cmd(OP_CANCEL, 4'd5, 31'd0, 1'b0, 30'd0, 63'd0);
    add_cmd(OP_CANCEL, 4'd6, 31'd0, 1'b0, 30'd0, 63'd0);
    add_cmd(OP_TICK, 4'd0, 31'd0, 1'b0, 30'd0, 63'h7FFFFFFFFFFFFFFF);
    wait_drained(DRAIN_WAIT);

    // phase with zero seed and no idling, sender pauses after it
    write_seed(16'd0);
    t_now   = 63'd1000;
    no_idle = 1;
    random_cmds(110);
    wait_drained(DRAIN_WAIT);
    no_idle = 0;

    // maximum seed, long output hold-off while commands keep coming
    write_seed(16'hFFFF);
    hold_req = 1;
    random_cmds(110);
    wait_drained(DRAIN_WAIT);

    write_seed(16'd1);
    random_cmds(110);
    wait_drained(DRAIN_WAIT);

    write_seed(16'($urandom_range(2, 65534)));
    random_cmds(110);
    wait_drained(DRAIN_WAIT);

    $display("ran %0d commands (%0d ticks) and checked %0d timer events", n_cmds, n_ticks,
             n_events);
    $display("seeds 0, 1, 0xffff and random; output hold-off and drained pauses applied");
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- periodic_timer_queue.f -----
+incdir+rtl
rtl/ptq_pkg.sv
rtl/ptq_if.sv
rtl/ptq_cell.sv
rtl/ptq_div.sv
rtl/ptq_ctrl.sv
rtl/periodic_timer_queue.sv
tb/tb_periodic_timer_queue.sv
